// ----- hw/rtl/tcls_pkg.sv -----
package tcls_pkg;

  localparam int unsigned FIELD_W   = 16;
  localparam int unsigned CFG_AW    = 3;
  localparam int unsigned STOP_DIST = 300;

  // sweep phase
  localparam logic [1:0] PH_IDLE   = 2'd0;
  localparam logic [1:0] PH_SWEEP  = 2'd1;
  localparam logic [1:0] PH_VERIFY = 2'd2;

  // item modes
  localparam logic [1:0] MODE_START  = 2'd0;
  localparam logic [1:0] MODE_SAMPLE = 2'd1;
  localparam logic [1:0] MODE_ANSWER = 2'd2;

  // detect answers
  localparam logic [1:0] DET_NONE   = 2'd0;
  localparam logic [1:0] DET_SIGNAL = 2'd1;

  // result codes
  localparam logic [2:0] ST_TUNE     = 3'd0;
  localparam logic [2:0] ST_VERIFY   = 3'd1;
  localparam logic [2:0] ST_FOUND    = 3'd2;
  localparam logic [2:0] ST_NOTFOUND = 3'd3;
  localparam logic [2:0] ST_ABORTED  = 3'd4;
  localparam logic [2:0] ST_IGNORED  = 3'd5;

  // register indexes
  localparam logic REG_MIN = 1'b0;
  localparam logic REG_MAX = 1'b1;

  localparam logic [3:0] AFC_NIB_MASK = 4'hf;
  localparam logic [7:0] LOCK_MASK    = 8'h50;
  localparam logic [4:0] AFC_ALL      = 5'h1f;
  localparam logic [4:0] AFC_LOW_A    = 5'h1b;
  localparam logic [4:0] AFC_LOW_B    = 5'h1a;
  localparam logic [4:0] AFC_BELOW    = 5'h0a;
  localparam logic [4:0] AFC_ABOVE    = 5'h10;
  localparam logic [4:0] AFC_TOWARD   = 5'h01;
  localparam logic [4:0] AFC_AWAY     = 5'h02;
  localparam logic [4:0] AFC_CENTRE   = 5'h04;

  typedef struct packed {
    logic [1:0]         mode;
    logic [FIELD_W-1:0] start_freq;
    logic               search_up;
    logic [7:0]         pll_status;
    logic               stop_request;
    logic [1:0]         detect_result;
  } tcls_item_t;

  typedef struct packed {
    logic [2:0]         status_code;
    logic [FIELD_W-1:0] tune_freq;
    logic [FIELD_W-1:0] found_freq;
  } tcls_res_t;

  function automatic logic [7:0] sat_inc(input logic [7:0] v);
    return (v == 8'hff) ? v : v + 8'd1;
  endfunction

endpackage

// ----- hw/rtl/tv_channel_lock_sweep.sv -----
// flow: the input transfer loads the item register; the result then passes into the result
// register, which drives the outputs
// throughput: one item per cycle while out_stall is low; the step logic updates the sweep state once per item
// reset: synchronous active-low rst_n clears the valid bits of both stages, the sweep state (phase idle,
// words, flags and counters zero) and sets min_freq 0 and max_freq all ones
module tv_channel_lock_sweep #(
  parameter int FREQ_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [1:0]                    in_mode,
  input  logic [tcls_pkg::FIELD_W-1:0]  in_start_freq,
  input  logic                          in_search_up,
  input  logic [7:0]                    in_pll_status,
  input  logic                          in_stop_request,
  input  logic [1:0]                    in_detect_result,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [2:0]                    out_status_code,
  output logic [tcls_pkg::FIELD_W-1:0]  out_tune_freq,
  output logic [tcls_pkg::FIELD_W-1:0]  out_found_freq,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [tcls_pkg::CFG_AW-1:0]   paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);
  import tcls_pkg::*;

  logic                 s1_v_r, s1_v_nxt;
  tcls_item_t           item_r;
  logic                 out_v_r, out_v_nxt;
  tcls_res_t            res_r;
  tcls_res_t            res;
  logic                 out_free;
  logic                 s1_fire;
  logic                 in_acc;
  logic [FREQ_BITS-1:0] min_freq, max_freq;

  tcls_cfg #(.FREQ_BITS(FREQ_BITS)) u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .min_freq (min_freq),
    .max_freq (max_freq)
  );

  tcls_core #(.FREQ_BITS(FREQ_BITS)) u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .fire     (s1_fire),
    .item     (item_r),
    .min_freq (min_freq),
    .max_freq (max_freq),
    .res      (res)
  );

  assign out_free = !out_v_r || !out_stall;
  assign s1_fire  = s1_v_r && out_free;
  assign in_stall = s1_v_r && !out_free;
  assign in_acc   = in_valid && !in_stall;

  assign s1_v_nxt  = in_acc || (s1_v_r && !out_free);
  assign out_v_nxt = out_free ? s1_fire : 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      s1_v_r  <= s1_v_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      item_r.mode          <= in_mode;
      item_r.start_freq    <= in_start_freq;
      item_r.search_up     <= in_search_up;
      item_r.pll_status    <= in_pll_status;
      item_r.stop_request  <= in_stop_request;
      item_r.detect_result <= in_detect_result;
    end
    if (s1_fire) res_r <= res;
  end

  assign out_valid       = out_v_r;
  assign out_status_code = res_r.status_code;
  assign out_tune_freq   = res_r.tune_freq;
  assign out_found_freq  = res_r.found_freq;

  a_fire_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    s1_fire |=> out_valid)
    else $error("processed item did not reach the result register");

  a_stall_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> s1_v_r)
    else $error("input stalled with an empty item register");

  a_found_matches_tune: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status_code == ST_FOUND) |-> (out_found_freq == out_tune_freq))
    else $error("found word differs from tuned word");

  a_found_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status_code != ST_FOUND) |-> (out_found_freq == '0))
    else $error("found word set on a result that is not found");

  a_no_pass_through: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> !s1_fire || !out_stall || !$past(out_stall))
    else $error("result register overwritten while held");

endmodule

// ----- hw/rtl/tcls_cfg.sv -----
module tcls_cfg #(
  parameter int FREQ_BITS = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [tcls_pkg::CFG_AW-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  output logic [FREQ_BITS-1:0]        min_freq,
  output logic [FREQ_BITS-1:0]        max_freq
);
  import tcls_pkg::*;

  logic [FREQ_BITS-1:0] min_r, max_r;
  logic                 wr_en;
  logic                 idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;
  assign idx    = paddr[2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_r <= '0;
      max_r <= '1;
    end else if (wr_en) begin
      if (idx == REG_MIN) min_r <= pwdata[FREQ_BITS-1:0];
      else                max_r <= pwdata[FREQ_BITS-1:0];
    end
  end

  always_comb begin
    if (idx == REG_MIN) prdata = 32'(min_r);
    else                prdata = 32'(max_r);
  end

  assign min_freq = min_r;
  assign max_freq = max_r;

endmodule

// ----- hw/rtl/tcls_core.sv -----
module tcls_core #(
  parameter int FREQ_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 fire,
  input  tcls_pkg::tcls_item_t item,
  input  logic [FREQ_BITS-1:0] min_freq,
  input  logic [FREQ_BITS-1:0] max_freq,
  output tcls_pkg::tcls_res_t  res
);
  import tcls_pkg::*;

  logic [1:0]           phase_r, phase_nxt;
  logic [FREQ_BITS-1:0] cur_r, cur_nxt;
  logic [FREQ_BITS-1:0] base_r, base_nxt;
  logic                 dir_r, dir_nxt;
  logic [4:0]           afc_r, afc_nxt;
  logic [7:0]           hits_r, hits_nxt;
  logic [7:0]           run_r, run_nxt;
  logic [FREQ_BITS-1:0] cand_r, cand_nxt;

  logic [3:0]           nib;
  logic                 far;
  logic                 at_lim;
  logic [FREQ_BITS-1:0] step_freq;
  logic [4:0]           afc_d;
  logic [7:0]           hits_d;
  logic [7:0]           run_d;
  logic [FREQ_BITS-1:0] cand_d;
  logic                 locked;
  logic                 hit_ok;
  logic                 do_adv;

  assign nib       = item.pll_status[3:0] & AFC_NIB_MASK;
  assign at_lim    = dir_r ? (cur_r >= max_freq) : (cur_r <= min_freq);
  assign step_freq = dir_r ? cur_r + FREQ_BITS'(1) : cur_r - FREQ_BITS'(1);
  assign locked    = (item.pll_status & LOCK_MASK) == LOCK_MASK;

  always_comb begin
    if (dir_r)
      far = (cur_r > base_r) && ((cur_r - base_r) > FREQ_BITS'(STOP_DIST));
    else
      far = (cur_r < base_r) && ((base_r - cur_r) > FREQ_BITS'(STOP_DIST));
  end

  // afc decode and counter update for a status sample
  always_comb begin
    afc_d  = afc_r;
    hits_d = hits_r;
    cand_d = cand_r;
    if (nib == 4'd7 || nib == 4'd8) begin
      if ((nib == 4'd7) == dir_r) begin
        afc_d = AFC_TOWARD;
      end else begin
        hits_d = sat_inc(hits_r);
        afc_d  = afc_r | AFC_AWAY;
      end
    end else if (nib inside {[4'd1:4'd6]}) begin
      afc_d = afc_r | AFC_BELOW;
    end else if (nib inside {[4'd9:4'd14]}) begin
      afc_d = afc_r | AFC_ABOVE;
    end else begin
      afc_d  = afc_r | AFC_CENTRE;
      cand_d = cur_r;
    end
    if (afc_d == AFC_LOW_A || afc_d == AFC_LOW_B) begin
      run_d = sat_inc(run_r);
      if (cand_d == '0) cand_d = cur_r;
    end else begin
      run_d = 8'd0;
    end
    hit_ok = dir_r ? (hits_d > 8'd3) : (hits_d > 8'd0);
  end

  always_comb begin
    phase_nxt = phase_r;
    cur_nxt   = cur_r;
    base_nxt  = base_r;
    dir_nxt   = dir_r;
    afc_nxt   = afc_r;
    hits_nxt  = hits_r;
    run_nxt   = run_r;
    cand_nxt  = cand_r;
    do_adv    = 1'b0;
    res.status_code = ST_IGNORED;
    res.tune_freq   = FIELD_W'(cur_r);
    res.found_freq  = '0;

    case (item.mode)
      MODE_START: begin
        cur_nxt   = item.start_freq[FREQ_BITS-1:0];
        base_nxt  = item.start_freq[FREQ_BITS-1:0];
        dir_nxt   = item.search_up;
        afc_nxt   = '0;
        hits_nxt  = '0;
        run_nxt   = '0;
        cand_nxt  = '0;
        phase_nxt = PH_SWEEP;
        res.status_code = ST_TUNE;
        res.tune_freq   = FIELD_W'(item.start_freq[FREQ_BITS-1:0]);
      end
      MODE_SAMPLE: begin
        if (phase_r == PH_SWEEP) begin
          if (far && item.stop_request) begin
            phase_nxt = PH_IDLE;
            res.status_code = ST_ABORTED;
          end else begin
            afc_nxt  = afc_d;
            hits_nxt = hits_d;
            run_nxt  = run_d;
            cand_nxt = cand_d;
            if (!locked) begin
              afc_nxt  = '0;
              hits_nxt = '0;
              do_adv   = 1'b1;
            end else if ((afc_d == AFC_ALL || run_d > 8'd4) && hit_ok) begin
              phase_nxt = PH_VERIFY;
              res.status_code = ST_VERIFY;
              res.tune_freq   = FIELD_W'(cand_d);
            end else begin
              do_adv = 1'b1;
            end
          end
        end
      end
      MODE_ANSWER: begin
        if (phase_r == PH_VERIFY) begin
          if (item.detect_result == DET_SIGNAL) begin
            phase_nxt = PH_IDLE;
            res.status_code = ST_FOUND;
            res.tune_freq   = FIELD_W'(cand_r);
            res.found_freq  = FIELD_W'(cand_r);
          end else begin
            if (item.detect_result == DET_NONE) begin
              run_nxt  = '0;
              afc_nxt  = '0;
              hits_nxt = '0;
            end
            cand_nxt  = '0;
            phase_nxt = PH_SWEEP;
            do_adv    = 1'b1;
          end
        end
      end
      default: begin
        phase_nxt = phase_r;
      end
    endcase

    // limit check comes before the step so the word never wraps
    if (do_adv) begin
      if (at_lim) begin
        phase_nxt = PH_IDLE;
        res.status_code = ST_NOTFOUND;
        res.tune_freq   = FIELD_W'(cur_r);
      end else begin
        cur_nxt = step_freq;
        res.status_code = ST_TUNE;
        res.tune_freq   = FIELD_W'(step_freq);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      cur_r   <= '0;
      base_r  <= '0;
      dir_r   <= 1'b0;
      afc_r   <= '0;
      hits_r  <= '0;
      run_r   <= '0;
      cand_r  <= '0;
    end else if (fire) begin
      phase_r <= phase_nxt;
      cur_r   <= cur_nxt;
      base_r  <= base_nxt;
      dir_r   <= dir_nxt;
      afc_r   <= afc_nxt;
      hits_r  <= hits_nxt;
      run_r   <= run_nxt;
      cand_r  <= cand_nxt;
    end
  end

endmodule

// ----- tb/sv/tcls_checker.sv -----
module tcls_checker #(
  parameter int FREQ_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  input  logic                         in_stall,
  input  logic [1:0]                   in_mode,
  input  logic [tcls_pkg::FIELD_W-1:0] in_start_freq,
  input  logic                         in_search_up,
  input  logic [7:0]                   in_pll_status,
  input  logic                         in_stop_request,
  input  logic [1:0]                   in_detect_result,
  input  logic                         out_valid,
  input  logic                         out_stall,
  input  logic [2:0]                   out_status_code,
  input  logic [tcls_pkg::FIELD_W-1:0] out_tune_freq,
  input  logic [tcls_pkg::FIELD_W-1:0] out_found_freq,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [tcls_pkg::CFG_AW-1:0]  paddr,
  input  logic [31:0]                  pwdata,
  input  logic                         pready,
  output int                           fail_count,
  output int                           pending
);
  timeunit 1ns;
  timeprecision 1ps;

  import tcls_pkg::*;

  localparam logic [15:0] FMASK = 16'((32'd1 << FREQ_BITS) - 32'd1);
  // afc nibbles that sit just either side of the carrier
  localparam logic [3:0] NIB_SIDE_A = 4'd7;
  localparam logic [3:0] NIB_SIDE_B = 4'd8;

  // sweep state as the block should hold it
  logic [1:0]  ph;
  logic [15:0] cur_word;
  logic [15:0] base_word;
  logic        dir_up;
  logic [4:0]  flags;
  logic [7:0]  hits;
  logic [7:0]  low_run;
  logic [15:0] cand_word;
  logic [15:0] lo_limit;
  logic [15:0] hi_limit;

  tcls_res_t answers_due[$];
  int        errs = 0;

  function automatic tcls_res_t make_res(input logic [2:0] code, input logic [15:0] tune,
                                         input logic [15:0] found);
    tcls_res_t r;
    r.status_code = code;
    r.tune_freq   = tune;
    r.found_freq  = found;
    return r;
  endfunction

  // limit check first, so the word never wraps
  function automatic tcls_res_t step_word();
    if (dir_up) begin
      if (cur_word >= hi_limit) begin
        ph = PH_IDLE;
        return make_res(ST_NOTFOUND, cur_word, 16'd0);
      end
      cur_word = (cur_word + 16'd1) & FMASK;
    end else begin
      if (cur_word <= lo_limit) begin
        ph = PH_IDLE;
        return make_res(ST_NOTFOUND, cur_word, 16'd0);
      end
      cur_word = (cur_word - 16'd1) & FMASK;
    end
    return make_res(ST_TUNE, cur_word, 16'd0);
  endfunction

  function automatic tcls_res_t take_sample(input logic [7:0] st, input logic stop);
    logic       far;
    logic [3:0] nib;
    nib = st[3:0] & AFC_NIB_MASK;
    if (dir_up)
      far = (cur_word > base_word) && ((cur_word - base_word) > 16'(STOP_DIST));
    else
      far = (cur_word < base_word) && ((base_word - cur_word) > 16'(STOP_DIST));
    if (far && stop) begin
      ph = PH_IDLE;
      return make_res(ST_ABORTED, cur_word, 16'd0);
    end

    if (nib == NIB_SIDE_A || nib == NIB_SIDE_B) begin
      if ((nib == NIB_SIDE_A) == dir_up) begin
        flags = AFC_TOWARD;
      end else begin
        if (hits != 8'hff) hits = hits + 8'd1;
        flags = flags | AFC_AWAY;
      end
    end else if (nib >= 4'd1 && nib <= 4'd6) begin
      flags = flags | AFC_BELOW;
    end else if (nib >= 4'd9 && nib <= 4'd14) begin
      flags = flags | AFC_ABOVE;
    end else begin
      flags = flags | AFC_CENTRE;
      cand_word = cur_word;
    end

    if (flags == AFC_LOW_A || flags == AFC_LOW_B) begin
      if (low_run != 8'hff) low_run = low_run + 8'd1;
      if (cand_word == 16'd0) cand_word = cur_word;
    end else begin
      low_run = 8'd0;
    end

    if ((st & LOCK_MASK) != LOCK_MASK) begin
      flags = 5'd0;
      hits  = 8'd0;
    end else if ((flags == AFC_ALL || low_run > 8'd4) &&
                 (dir_up ? (hits > 8'd3) : (hits > 8'd0))) begin
      ph = PH_VERIFY;
      return make_res(ST_VERIFY, cand_word, 16'd0);
    end
    return step_word();
  endfunction

  function automatic tcls_res_t take_answer(input logic [1:0] det);
    if (det == DET_SIGNAL) begin
      ph = PH_IDLE;
      return make_res(ST_FOUND, cand_word, cand_word);
    end
    if (det == DET_NONE) begin
      low_run = 8'd0;
      flags   = 5'd0;
      hits    = 8'd0;
    end
    cand_word = 16'd0;
    ph = PH_SWEEP;
    return step_word();
  endfunction

  function automatic tcls_res_t next_sweep_result(input logic [1:0] m, input logic [15:0] sf,
                                                  input logic up, input logic [7:0] st,
                                                  input logic stop, input logic [1:0] det);
    if (m == MODE_START) begin
      cur_word  = sf & FMASK;
      base_word = cur_word;
      dir_up    = up;
      flags     = 5'd0;
      hits      = 8'd0;
      low_run   = 8'd0;
      cand_word = 16'd0;
      ph        = PH_SWEEP;
      return make_res(ST_TUNE, cur_word, 16'd0);
    end
    if (m == MODE_SAMPLE && ph == PH_SWEEP) return take_sample(st, stop);
    if (m == MODE_ANSWER && ph == PH_VERIFY) return take_answer(det);
    return make_res(ST_IGNORED, cur_word, 16'd0);
  endfunction

  task automatic report(input string what, input int unsigned want, input int unsigned got);
    $display("%0t %s mismatch: expected %0d actual %0d", $time, what, want, got);
    errs++;
  endtask

  always @(posedge clk) begin : watch
    tcls_res_t want;
    if (!rst_n) begin
      ph        = PH_IDLE;
      cur_word  = 16'd0;
      base_word = 16'd0;
      dir_up    = 1'b0;
      flags     = 5'd0;
      hits      = 8'd0;
      low_run   = 8'd0;
      cand_word = 16'd0;
      lo_limit  = 16'd0;
      hi_limit  = FMASK;
      answers_due.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        if (paddr[2] == REG_MIN) lo_limit = pwdata[15:0] & FMASK;
        else hi_limit = pwdata[15:0] & FMASK;
      end
      if (in_valid && !in_stall)
        answers_due.push_back(next_sweep_result(in_mode, in_start_freq, in_search_up,
                                                in_pll_status, in_stop_request,
                                                in_detect_result));
      if (out_valid && !out_stall) begin
        if (answers_due.size() == 0) begin
          $display("%0t unexpected result: status_code %0d tune_freq %0d found_freq %0d",
                   $time, out_status_code, out_tune_freq, out_found_freq);
          errs++;
        end else begin
          want = answers_due.pop_front();
          if (out_status_code !== want.status_code)
            report("status_code", 32'(want.status_code), 32'(out_status_code));
          if (out_tune_freq !== want.tune_freq)
            report("tune_freq", 32'(want.tune_freq), 32'(out_tune_freq));
          if (out_found_freq !== want.found_freq)
            report("found_freq", 32'(want.found_freq), 32'(out_found_freq));
        end
      end
    end
    fail_count <= errs;
    pending    <= answers_due.size();
  end

endmodule

// ----- tb/sv/tb_tv_channel_lock_sweep.sv -----
module tb_tv_channel_lock_sweep;
  timeunit 1ns;
  timeprecision 1ps;

  import tcls_pkg::*;

  localparam int         CYCLE_LIMIT = 1000000;
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  logic                clk              = 1'b0;
  logic                rst_n            = 1'b0;
  logic                in_valid         = 1'b0;
  logic [1:0]          in_mode          = MODE_START;
  logic [FIELD_W-1:0]  in_start_freq    = '0;
  logic                in_search_up     = 1'b0;
  logic [7:0]          in_pll_status    = 8'd0;
  logic                in_stop_request  = 1'b0;
  logic [1:0]          in_detect_result = DET_NONE;
  logic                out_stall        = 1'b0;
  logic                psel             = 1'b0;
  logic                penable          = 1'b0;
  logic                pwrite           = 1'b0;
  logic [CFG_AW-1:0]   paddr            = '0;
  logic [31:0]         pwdata           = 32'd0;

  logic                in_stall;
  logic                out_valid;
  logic [2:0]          out_status_code;
  logic [FIELD_W-1:0]  out_tune_freq;
  logic [FIELD_W-1:0]  out_found_freq;
  logic [31:0]         prdata;
  logic                pready;

  int fail_count;
  int pending;
  int cycles       = 0;
  int stall_left   = 0;
  int recv_calm    = 0;
  int sender_calm  = 0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  tv_channel_lock_sweep #(.FREQ_BITS(16)) DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_mode(in_mode), .in_start_freq(in_start_freq), .in_search_up(in_search_up),
    .in_pll_status(in_pll_status), .in_stop_request(in_stop_request),
    .in_detect_result(in_detect_result),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_status_code(out_status_code), .out_tune_freq(out_tune_freq),
    .out_found_freq(out_found_freq),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  tcls_checker #(.FREQ_BITS(16)) lock_chk (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_mode(in_mode), .in_start_freq(in_start_freq), .in_search_up(in_search_up),
    .in_pll_status(in_pll_status), .in_stop_request(in_stop_request),
    .in_detect_result(in_detect_result),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_status_code(out_status_code), .out_tune_freq(out_tune_freq),
    .out_found_freq(out_found_freq),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .pready(pready),
    .fail_count(fail_count), .pending(pending)
  );

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t timeout with %0d results outstanding", $time, pending);
      $display("== FAIL ==");
      $finish;
    end
  end

  // result side back-pressure: mostly short stalls, a few long, some calm stretches
  always @(posedge clk) begin : recv_side
    int r;
    if (stall_left == 0 && recv_calm == 0) begin
      r = $urandom_range(0, 99);
      if (r < 2) recv_calm = $urandom_range(50, 200);
      else if (r < 22) stall_left = $urandom_range(1, 3);
      else if (r < 27) stall_left = $urandom_range(4, 12);
      else if (r < 28) stall_left = $urandom_range(20, 80);
    end
    if (recv_calm > 0) recv_calm--;
    out_stall <= (stall_left > 0);
    if (stall_left > 0) stall_left--;
  end

  function automatic int pick_gap();
    int r;
    if (sender_calm > 0) begin
      sender_calm--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) begin
      sender_calm = $urandom_range(30, 120);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(15, 60);
  endfunction

  // demodulator status with the afc nibble biased towards the interesting codes
  function automatic logic [7:0] pick_status(input int lock_pct);
    logic [7:0] st;
    int         r;
    st = 8'($urandom);
    r  = $urandom_range(0, 99);
    if (r < 30) st[3:0] = 4'($urandom_range(7, 8));
    else if (r < 45) st[3:0] = 4'($urandom_range(1, 6));
    else if (r < 60) st[3:0] = 4'($urandom_range(9, 14));
    else if (r < 70) st[3:0] = ($urandom_range(0, 1) != 0) ? 4'hf : 4'h0;
    if ($urandom_range(0, 99) < lock_pct) begin
      st = st | LOCK_MASK;
    end else if ((st & LOCK_MASK) == LOCK_MASK) begin
      if ($urandom_range(0, 1) != 0) st[4] = 1'b0;
      else st[6] = 1'b0;
    end
    return st;
  endfunction

  // one transfer on the input channel; unused fields carry whatever the caller gives
  task automatic send_item(input logic [1:0] m, input logic [15:0] sf, input logic up,
                           input logic [7:0] st, input logic stop, input logic [1:0] det);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_mode          <= m;
    in_start_freq    <= sf;
    in_search_up     <= up;
    in_pll_status    <= st;
    in_stop_request  <= stop;
    in_detect_result <= det;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic start_sweep(input logic [15:0] sf, input logic up);
    send_item(MODE_START, sf, up, 8'($urandom), 1'($urandom), 2'($urandom));
  endtask

  task automatic sample(input logic [7:0] st, input logic stop);
    send_item(MODE_SAMPLE, 16'($urandom), 1'($urandom), st, stop, 2'($urandom));
  endtask

  task automatic answer(input logic [1:0] det);
    send_item(MODE_ANSWER, 16'($urandom), 1'($urandom), 8'($urandom), 1'($urandom), det);
  endtask

  task automatic junk();
    send_item(MODE_UNUSED, 16'($urandom), 1'($urandom), 8'($urandom), 1'($urandom),
              2'($urandom));
  endtask

  // hold the sender until every outstanding result has come back
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic program_reg(input logic idx, input logic [15:0] val);
    logic [15:0] upper;
    upper   = 16'($urandom);
    paddr   <= {idx, 2'b00};
    pwdata  <= {upper, val};
    pwrite  <= 1'b1;
    psel    <= 1'b1;
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_limits(input logic [15:0] lo, input logic [15:0] hi);
    settle();
    program_reg(REG_MIN, lo);
    program_reg(REG_MAX, hi);
  endtask

  // a start followed by n status samples, with detect answers and noise mixed in
  task automatic hunt(input logic up, input logic [15:0] sf, input int n, input int lock_pct,
                      input int ans_pct);
    int r;
    int d;
    start_sweep(sf, up);
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (r < ans_pct) begin
        d = $urandom_range(0, 99);
        if (d < 40) answer(DET_NONE);
        else if (d < 70) answer(DET_SIGNAL);
        else answer(2'($urandom_range(2, 3)));
      end else if (r < ans_pct + 3) begin
        junk();
      end
      if ($urandom_range(0, 199) == 0) settle();
      sample(pick_status(lock_pct), $urandom_range(0, 99) < 4);
    end
  endtask

  initial begin : stimulus
    logic [15:0] lo;
    logic [15:0] hi;
    logic [15:0] tmp;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    set_limits(16'h0000, 16'hffff);

    // floor and ceiling of the word: the first sample already hits the limit
    start_sweep(16'h0000, 1'b0);
    sample(8'h57, 1'b1);
    // idle block: sample, answer and the unused mode are all ignored
    sample(8'h50, 1'b0);
    answer(DET_SIGNAL);
    junk();
    start_sweep(16'hffff, 1'b1);
    sample(8'hff, 1'b0);

    // upward lock: toward, four away hits, below, above, centre
    start_sweep(16'h8000, 1'b1);
    sample(8'h57, 1'b0);
    sample(8'hd8, 1'b1);
    sample(8'h58, 1'b0);
    sample(8'h78, 1'b0);
    sample(8'h58, 1'b0);
    sample(8'h53, 1'b0);
    sample(8'h5a, 1'b0);
    sample(8'h50, 1'b0);
    sample(8'h50, 1'b0);
    answer(2'd2);
    sample(8'h5f, 1'b0);
    answer(DET_SIGNAL);

    // downward lock, rejected by the detector, then lock bits missing
    start_sweep(16'h4000, 1'b0);
    sample(8'h57, 1'b0);
    sample(8'h58, 1'b0);
    sample(8'h52, 1'b0);
    sample(8'h5c, 1'b0);
    sample(8'h5f, 1'b0);
    answer(DET_NONE);
    sample(8'h17, 1'b0);
    answer(2'd3);
    settle();

    repeat (8) hunt(1'($urandom_range(0, 1)), 16'($urandom), $urandom_range(8, 35), 90, 15);

    // narrow window so the limits are reached often
    set_limits(16'd1000, 16'd1030);
    repeat (5) hunt(1'($urandom_range(0, 1)), 16'($urandom_range(990, 1040)),
                    $urandom_range(10, 30), 80, 15);

    // inverted extremes: every step is already past the limit
    set_limits(16'hffff, 16'h0000);
    repeat (6) hunt(1'($urandom_range(0, 1)), 16'($urandom), $urandom_range(2, 4), 90, 15);

    repeat (2) begin
      lo = 16'($urandom);
      hi = 16'($urandom);
      if (lo > hi) begin
        tmp = lo;
        lo  = hi;
        hi  = tmp;
      end
      set_limits(lo, hi);
      repeat (4) hunt(1'($urandom_range(0, 1)), 16'($urandom_range(lo, hi)),
                      $urandom_range(10, 30), 85, 15);
    end

    // long runs past the stop distance so a stop request aborts
    set_limits(16'h0000, 16'hffff);
    hunt(1'b1, 16'($urandom_range(0, 16'h8000)), 320, 0, 2);
    sample(pick_status(0), 1'b1);
    hunt(1'b0, 16'($urandom_range(16'h8000, 16'hffff)), 320, 10, 2);
    sample(pick_status(10), 1'b1);

    settle();
    repeat (10) @(posedge clk);
    if (fail_count == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

endmodule
